@@ hdl/tkrs_pkg.sv @@
// Shared types and constants for the top-k / range candidate selector.
package tkrs_pkg;

   // Operation codes of a request beat
   localparam logic [1:0] OP_CAND  = 2'd0;
   localparam logic [1:0] OP_BEGIN = 2'd1;
   localparam logic [1:0] OP_CLEAR = 2'd2;
   localparam logic [1:0] OP_DRAIN = 2'd3;

   // Register indexes on the csr port
   localparam logic [2:0] CSR_MODE   = 3'd0;
   localparam logic [2:0] CSR_FILTER = 3'd1;
   localparam logic [2:0] CSR_K      = 3'd2;
   localparam logic [2:0] CSR_RADIUS = 3'd3;
   localparam logic [2:0] CSR_LIMIT  = 3'd4;

   // Most results returned by one drain
   localparam int DRAIN_MAX = 64;
   localparam int REM_W     = 7;
   localparam int FRAC_BITS = 16;

   // Controller to datapath
   typedef struct packed {
      logic accept;
      logic scan_rd;
      logic scan_shift;
      logic write_new;
      logic post;
      logic thr_upd;
      logic dr_empty;
      logic dr_rd;
      logic dr_out;
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic admit;
      logic pos_zero;
      logic key_ge;
      logic cnt_zero;
      logic slot_free;
      logic rem_zero;
   } status_type;

endpackage

@@ hdl/topk_range_candidate_selector.sv @@
// Channels: req_ carries one beat per operation (candidate, begin window,
// clear store, drain); rsp_ returns drained entries; csr_ writes the five
// configuration registers and is always ready.
// Begin window and clear store complete on acceptance. A rejected
// candidate returns to idle after its admission check; an admitted one is
// inserted by walking the sorted store down from the top through its
// registered read port, moving each entry with a larger or equal key up
// one place and then writing the new entry below them.
// An empty store drains as one beat with rsp_out_valid low.
// rsp_ is a registered output: a pending response beat does not block new
// requests, but the next response waits until the current one is taken.
// Reset (synchronous) empties the store, sets the threshold to the largest
// distance, clears the window base and overflow flag and loads register
// defaults. The store itself needs no clearing pass.
module topk_range_candidate_selector #(
   parameter int STORE_DEPTH = 64,
   parameter int DIST_WIDTH  = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_operation,
   input  logic [31:0]        req_cand_index,
   input  logic signed [31:0] req_cand_dist,
   input  logic               req_allowed,
   input  logic [31:0]        req_id_offset,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic               rsp_out_valid,
   output logic [31:0]        rsp_out_id,
   output logic signed [31:0] rsp_out_dist,
   output logic               rsp_last,
   output logic               rsp_overflow,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [2:0]         csr_index,
   input  logic [31:0]        csr_wdata
);
   import tkrs_pkg::*;

   cmd_type    cmd;
   status_type status;

   assign csr_ready = 1'b1;

   tkrs_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_operation (req_operation),
      .req_ready     (req_ready),
      .status        (status),
      .cmd           (cmd)
   );

   tkrs_dpath #(
      .STORE_DEPTH (STORE_DEPTH),
      .DIST_WIDTH  (DIST_WIDTH)
   ) u_dpath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .req_operation  (req_operation),
      .req_cand_index (req_cand_index),
      .req_cand_dist  (req_cand_dist),
      .req_allowed    (req_allowed),
      .req_id_offset  (req_id_offset),
      .csr_valid      (csr_valid),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_out_valid  (rsp_out_valid),
      .rsp_out_id     (rsp_out_id),
      .rsp_out_dist   (rsp_out_dist),
      .rsp_last       (rsp_last),
      .rsp_overflow   (rsp_overflow)
   );
endmodule

@@ hdl/tkrs_ctrl.sv @@
// Sequencer for candidate insertion and drain readout.
module tkrs_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic [1:0]           req_operation,
   output logic                 req_ready,
   input  tkrs_pkg::status_type status,
   output tkrs_pkg::cmd_type    cmd
);
   import tkrs_pkg::*;

   localparam logic [3:0] ST_IDLE     = 4'd0;
   localparam logic [3:0] ST_CAND     = 4'd1;
   localparam logic [3:0] ST_SCAN_RD  = 4'd2;
   localparam logic [3:0] ST_SCAN_CMP = 4'd3;
   localparam logic [3:0] ST_POST     = 4'd4;
   localparam logic [3:0] ST_THR      = 4'd5;
   localparam logic [3:0] ST_DR_CHK   = 4'd6;
   localparam logic [3:0] ST_DR_RD    = 4'd7;
   localparam logic [3:0] ST_DR_OUT   = 4'd8;

   logic [3:0] state_ff, state_in;

   assign req_ready = (state_ff == ST_IDLE);

   // Next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               if (req_operation == OP_CAND) state_in = ST_CAND;
               else if (req_operation == OP_DRAIN) state_in = ST_DR_CHK;
            end
         end
         ST_CAND: state_in = status.admit ? ST_SCAN_RD : ST_IDLE;
         ST_SCAN_RD: begin
            if (status.pos_zero) begin
               cmd.write_new = 1'b1;
               state_in      = ST_POST;
            end else begin
               cmd.scan_rd = 1'b1;
               state_in    = ST_SCAN_CMP;
            end
         end
         ST_SCAN_CMP: begin
            if (status.key_ge) begin
               cmd.scan_shift = 1'b1;
               state_in       = ST_SCAN_RD;
            end else begin
               cmd.write_new = 1'b1;
               state_in      = ST_POST;
            end
         end
         ST_POST: begin
            cmd.post = 1'b1;
            state_in = ST_THR;
         end
         ST_THR: begin
            cmd.thr_upd = 1'b1;
            state_in    = ST_IDLE;
         end
         ST_DR_CHK: begin
            if (!status.cnt_zero) state_in = ST_DR_RD;
            else if (status.slot_free) begin
               cmd.dr_empty = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         ST_DR_RD: begin
            cmd.dr_rd = 1'b1;
            state_in  = ST_DR_OUT;
         end
         ST_DR_OUT: begin
            if (status.slot_free) begin
               cmd.dr_out = 1'b1;
               state_in   = status.rem_zero ? ST_IDLE : ST_DR_RD;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else state_ff <= state_in;
   end
endmodule

@@ hdl/tkrs_dpath.sv @@
// Datapath: entry store, counters, threshold, config and response register.
module tkrs_dpath #(
   parameter int STORE_DEPTH = 64,
   parameter int DIST_WIDTH  = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  tkrs_pkg::cmd_type    cmd,
   output tkrs_pkg::status_type status,
   input  logic [1:0]           req_operation,
   input  logic [31:0]          req_cand_index,
   input  logic signed [31:0]   req_cand_dist,
   input  logic                 req_allowed,
   input  logic [31:0]          req_id_offset,
   input  logic                 csr_valid,
   input  logic [2:0]           csr_index,
   input  logic [31:0]          csr_wdata,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic                 rsp_out_valid,
   output logic [31:0]          rsp_out_id,
   output logic signed [31:0]   rsp_out_dist,
   output logic                 rsp_last,
   output logic                 rsp_overflow
);
   import tkrs_pkg::*;

   localparam int MEM_N = STORE_DEPTH + 1;
   localparam int AW    = $clog2(MEM_N);
   localparam int CW    = $clog2(STORE_DEPTH + 2);
   localparam int KW    = (CW > 8) ? CW : 8;
   localparam int EW    = DIST_WIDTH + 32;
   localparam logic signed [32:0] DMAX33 = (33'sd1 <<< (DIST_WIDTH - 1)) - 33'sd1;
   localparam logic signed [32:0] DMIN33 = -(33'sd1 <<< (DIST_WIDTH - 1));
   localparam logic signed [DIST_WIDTH-1:0] DMAX = DMAX33[DIST_WIDTH-1:0];

   // Config registers
   logic               mode_ff, filt_ff;
   logic [6:0]         k_ff;
   logic signed [31:0] rad_ff;
   logic [7:0]         lim_ff;

   // Block state
   logic [CW-1:0]                 cnt_ff, cnt_in;
   logic signed [DIST_WIDTH-1:0]  thr_ff, thr_in;
   logic [31:0]                   base_ff;
   logic                          ovf_ff, ovf_in;

   // Working registers
   logic signed [DIST_WIDTH-1:0]  nd_ff;
   logic [31:0]                   nid_ff;
   logic                          ok_ff;
   logic [CW-1:0]                 pos_ff;
   logic [REM_W-1:0]              rem_ff;
   logic                          all_ff;

   // Store, ascending: the largest key sits at cnt-1
   logic [EW-1:0] mem [MEM_N];
   logic [EW-1:0] rd_ff;
   logic          rd_en;
   logic [AW-1:0] rd_addr;
   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic [EW-1:0] wr_data;

   logic signed [DIST_WIDTH-1:0] rd_d;
   logic [31:0]                  rd_id;
   assign rd_d  = rd_ff[EW-1:32];
   assign rd_id = rd_ff[31:0];

   // Response register
   logic               rv_ff, rov_ff, rlast_ff, rovf_ff;
   logic [31:0]        rid_ff;
   logic signed [31:0] rdist_ff;
   logic               slot_free;
   assign slot_free     = !rv_ff || rsp_ready;
   assign rsp_valid     = rv_ff;
   assign rsp_out_valid = rov_ff;
   assign rsp_out_id    = rid_ff;
   assign rsp_out_dist  = rdist_ff;
   assign rsp_last      = rlast_ff;
   assign rsp_overflow  = rovf_ff;

   // Range threshold: radius minus 1.0 (1 << FRAC_BITS), saturated to the distance range
   logic signed [32:0] r33;
   logic signed [DIST_WIDTH-1:0] rad_thr, thr_rst;
   always_comb begin
      r33 = 33'($signed(rad_ff)) - (33'sd1 <<< FRAC_BITS);
      if (r33 > DMAX33) rad_thr = DMAX;
      else if (r33 < DMIN33) rad_thr = DMIN33[DIST_WIDTH-1:0];
      else rad_thr = r33[DIST_WIDTH-1:0];
      thr_rst = mode_ff ? rad_thr : DMAX;
   end

   // Admission decision and count arithmetic
   logic [KW-1:0] cnt_x, keff_x, lim_x, c1, c2, c3;
   logic          lim_pos, lim_zero, k_below, e1, e2, admit;
   always_comb begin
      cnt_x    = KW'(cnt_ff);
      keff_x   = (KW'(k_ff) > KW'(STORE_DEPTH)) ? KW'(STORE_DEPTH) : KW'(k_ff);
      lim_x    = KW'(lim_ff[6:0]);
      lim_zero = (lim_ff == 8'd0);
      lim_pos  = !lim_ff[7] && !lim_zero;
      k_below  = cnt_x < keff_x;
      if (!mode_ff) begin
         if (k_below) admit = (nd_ff < 0) && ok_ff;
         else admit = (cnt_ff != '0) && (nd_ff <= thr_ff) && ok_ff;
      end else begin
         admit = !lim_zero && (nd_ff <= thr_ff) && ok_ff;
      end
      c1 = cnt_x + KW'(1);
      e1 = 1'b0;
      e2 = 1'b0;
      if (!mode_ff) begin
         e1 = !k_below;
      end else begin
         e1 = lim_pos && (c1 > lim_x);
      end
      c2 = c1 - KW'(e1);
      if (mode_ff) e2 = c2 > KW'(STORE_DEPTH);
      c3 = c2 - KW'(e2);
   end

   logic key_ge;
   assign key_ge = (rd_d > nd_ff) || ((rd_d == nd_ff) && (rd_id >= nid_ff));

   assign status.admit     = admit;
   assign status.pos_zero  = (pos_ff == '0);
   assign status.key_ge    = key_ge;
   assign status.cnt_zero  = (cnt_ff == '0);
   assign status.slot_free = slot_free;
   assign status.rem_zero  = (rem_ff == '0);

   // Memory port selection
   always_comb begin
      rd_en   = cmd.scan_rd || cmd.post || cmd.dr_rd;
      if (cmd.post) rd_addr = AW'(c3 - KW'(1));
      else rd_addr = AW'(pos_ff - CW'(1));
      wr_en   = cmd.scan_shift || cmd.write_new;
      wr_addr = AW'(pos_ff);
      wr_data = cmd.scan_shift ? rd_ff : {nd_ff, nid_ff};
   end

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      if (rd_en) rd_ff <= mem[rd_addr];
   end

   // Count, threshold and overflow next values
   always_comb begin
      cnt_in = cnt_ff;
      thr_in = thr_ff;
      ovf_in = ovf_ff;
      if (cmd.accept && req_operation == OP_BEGIN) thr_in = thr_rst;
      if (cmd.accept && req_operation == OP_CLEAR) begin
         cnt_in = '0;
         ovf_in = 1'b0;
         thr_in = thr_rst;
      end
      if (cmd.post) begin
         cnt_in = CW'(c3);
         if (e2) ovf_in = 1'b1;
      end
      if (cmd.thr_upd) begin
         if (!mode_ff) thr_in = rd_d;
         else if (lim_pos && (cnt_x == lim_x)) thr_in = rd_d;
         else thr_in = rad_thr;
      end
      if (cmd.dr_empty) thr_in = thr_rst;
      if (cmd.dr_out && rem_ff == '0) begin
         cnt_in = pos_ff;
         thr_in = thr_rst;
      end
   end

   // State registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= 1'b0;
         filt_ff <= 1'b0;
         k_ff    <= 7'd10;
         rad_ff  <= '0;
         lim_ff  <= 8'hFF;
         cnt_ff  <= '0;
         thr_ff  <= DMAX;
         base_ff <= '0;
         ovf_ff  <= 1'b0;
         rv_ff   <= 1'b0;
      end else begin
         if (csr_valid) begin
            case (csr_index)
               CSR_MODE:   mode_ff <= csr_wdata[0];
               CSR_FILTER: filt_ff <= csr_wdata[0];
               CSR_K:      k_ff    <= csr_wdata[6:0];
               CSR_RADIUS: rad_ff  <= csr_wdata;
               CSR_LIMIT:  lim_ff  <= csr_wdata[7:0];
               default: ;
            endcase
         end
         cnt_ff <= cnt_in;
         thr_ff <= thr_in;
         ovf_ff <= ovf_in;
         if (cmd.accept && req_operation == OP_BEGIN) base_ff <= req_id_offset;
         if (cmd.dr_empty || cmd.dr_out) rv_ff <= 1'b1;
         else if (rsp_ready) rv_ff <= 1'b0;
      end
   end

   // Working registers and response payload
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         nd_ff  <= req_cand_dist[DIST_WIDTH-1:0];
         nid_ff <= req_cand_index + base_ff;
         ok_ff  <= !filt_ff || req_allowed;
         pos_ff <= cnt_ff;
         rem_ff <= (cnt_x > KW'(DRAIN_MAX)) ? REM_W'(DRAIN_MAX) : REM_W'(cnt_ff);
         all_ff <= cnt_x <= KW'(DRAIN_MAX);
      end
      if (cmd.scan_shift) pos_ff <= pos_ff - CW'(1);
      if (cmd.dr_rd) begin
         pos_ff <= pos_ff - CW'(1);
         rem_ff <= rem_ff - REM_W'(1);
      end
      if (cmd.dr_empty) begin
         rov_ff   <= 1'b0;
         rid_ff   <= '0;
         rdist_ff <= '0;
         rlast_ff <= 1'b1;
         rovf_ff  <= ovf_ff;
      end
      if (cmd.dr_out) begin
         rov_ff   <= 1'b1;
         rid_ff   <= rd_id;
         rdist_ff <= 32'(rd_d);
         rlast_ff <= (rem_ff == '0) && all_ff;
         rovf_ff  <= ovf_ff;
      end
   end
endmodule

@@ hdl/tkrs_checker.sv @@
// Port-level checker for the selector, bound to the top level.
module tkrs_checker (
   input logic               clock,
   input logic               reset,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic               rsp_out_valid,
   input logic [31:0]        rsp_out_id,
   input logic signed [31:0] rsp_out_dist,
   input logic               rsp_last
);
   // A stalled response beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_id) && $stable(rsp_out_dist))
      else $error("rsp beat changed while stalled");

   // An empty drain is a single closing beat
   a_empty_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_out_valid |-> rsp_last)
      else $error("empty drain beat without last");

   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_out_valid |-> rsp_out_id == 32'd0 && rsp_out_dist == 32'sd0)
      else $error("empty drain beat carries data");

   // Reset leaves no response pending
   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");
endmodule

bind topk_range_candidate_selector tkrs_checker u_tkrs_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_valid),
   .rsp_ready     (rsp_ready),
   .rsp_out_valid (rsp_out_valid),
   .rsp_out_id    (rsp_out_id),
   .rsp_out_dist  (rsp_out_dist),
   .rsp_last      (rsp_last)
);
